[sv/tbw_pkg.sv]
// shared constants, types and helpers for the barycentric weight unit
package tbw_pkg;

    localparam int COORD_BITS_DEF       = 16;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;

    // result weights are always 32-bit two's complement
    localparam int QUOT_W = 32;

    // register stages in the cross-term front end
    localparam int TERM_LAT = 5;
    // divider: one setup stage, one stage per quotient bit, one saturation stage
    localparam int DIV_LAT  = QUOT_W + 2;
    // start accepted to result strobe
    localparam int PIPE_LAT = TERM_LAT + DIV_LAT + 1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_A_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_C_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_C_Y = 3'd5;

    // magnitude width of the cross terms and their sum
    function automatic int mag_width(input int coord_bits);
        return 2 * (coord_bits + 1) + 2;
    endfunction

    // per-item flags leaving the front end
    typedef struct packed {
        logic       deg;
        logic [2:0] neg;
    } t_term_flags;

endpackage

[sv/tbw_terms.sv]
// front end: edge vectors, products, cross terms, sum, magnitudes and signs
module tbw_terms #(
    parameter int COORD_BITS = tbw_pkg::COORD_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    input  logic signed [COORD_BITS-1:0]               i_ax,
    input  logic signed [COORD_BITS-1:0]               i_ay,
    input  logic signed [COORD_BITS-1:0]               i_bx,
    input  logic signed [COORD_BITS-1:0]               i_by,
    input  logic signed [COORD_BITS-1:0]               i_cx,
    input  logic signed [COORD_BITS-1:0]               i_cy,
    input  logic signed [COORD_BITS-1:0]               i_px,
    input  logic signed [COORD_BITS-1:0]               i_py,
    output logic                                       o_valid,
    output logic [tbw_pkg::mag_width(COORD_BITS)-1:0]  o_num_mag [3],
    output logic [tbw_pkg::mag_width(COORD_BITS)-1:0]  o_den_mag,
    output tbw_pkg::t_term_flags                       o_flags
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;
    localparam int MW = tbw_pkg::mag_width(COORD_BITS);

    logic [tbw_pkg::TERM_LAT-1:0] r_vld;

    logic signed [DW-1:0] r_e [3];
    logic signed [DW-1:0] r_f [3];
    logic signed [PW-1:0] r_p [6];
    logic signed [SW-1:0] r_s [3];
    logic signed [MW-1:0] r_t [3];  // s0, s1, s0+s1
    logic signed [MW-1:0] r_d;      // s2

    logic [MW-1:0]        r_num_mag [3];
    logic [MW-1:0]        r_den_mag;
    tbw_pkg::t_term_flags r_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[tbw_pkg::TERM_LAT-2:0], i_valid};
        end
    end

    // stage 1: edge vectors
    always_ff @(posedge i_clk) begin
        r_e[0] <= DW'(i_bx) - DW'(i_ax);
        r_e[1] <= DW'(i_cx) - DW'(i_ax);
        r_e[2] <= DW'(i_ax) - DW'(i_px);
        r_f[0] <= DW'(i_by) - DW'(i_ay);
        r_f[1] <= DW'(i_cy) - DW'(i_ay);
        r_f[2] <= DW'(i_ay) - DW'(i_py);
    end

    // stage 2: six products
    always_ff @(posedge i_clk) begin
        r_p[0] <= PW'(r_e[1]) * PW'(r_f[2]);
        r_p[1] <= PW'(r_e[2]) * PW'(r_f[1]);
        r_p[2] <= PW'(r_e[2]) * PW'(r_f[0]);
        r_p[3] <= PW'(r_e[0]) * PW'(r_f[2]);
        r_p[4] <= PW'(r_e[0]) * PW'(r_f[1]);
        r_p[5] <= PW'(r_e[1]) * PW'(r_f[0]);
    end

    // stage 3: cross product components
    always_ff @(posedge i_clk) begin
        r_s[0] <= SW'(r_p[0]) - SW'(r_p[1]);
        r_s[1] <= SW'(r_p[2]) - SW'(r_p[3]);
        r_s[2] <= SW'(r_p[4]) - SW'(r_p[5]);
    end

    // stage 4: widened cross terms, their sum for the first weight, and the divisor
    always_ff @(posedge i_clk) begin
        r_t[0] <= MW'(r_s[0]);
        r_t[1] <= MW'(r_s[1]);
        r_t[2] <= MW'(r_s[0]) + MW'(r_s[1]);
        r_d    <= MW'(r_s[2]);
    end

    // stage 5: sign and magnitude split, zero-area flag
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_num_mag[k]   <= r_t[k][MW-1] ? MW'(-r_t[k]) : MW'(r_t[k]);
            r_flags.neg[k] <= r_t[k][MW-1] ^ r_d[MW-1];
        end
        r_den_mag   <= r_d[MW-1] ? MW'(-r_d) : MW'(r_d);
        r_flags.deg <= (r_d == '0);
    end

    assign o_valid   = r_vld[tbw_pkg::TERM_LAT-1];
    assign o_num_mag = r_num_mag;
    assign o_den_mag = r_den_mag;
    assign o_flags   = r_flags;

endmodule

[sv/tbw_div.sv]
// pipelined restoring divider, one quotient bit per stage, saturated signed result
module tbw_div #(
    parameter int MAG_W     = tbw_pkg::mag_width(tbw_pkg::COORD_BITS_DEF),
    parameter int FRAC_BITS = tbw_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic [MAG_W-1:0]                 i_num_mag,
    input  logic [MAG_W-1:0]                 i_den_mag,
    input  logic                             i_neg,
    output logic signed [tbw_pkg::QUOT_W-1:0] o_quot
);

    localparam int QW    = tbw_pkg::QUOT_W;
    localparam int EXT_W = QW + MAG_W;

    logic [MAG_W-1:0] r_rem [QW+1];
    logic [QW-1:0]    r_low [QW+1];
    logic [QW-1:0]    r_q   [QW+1];
    logic [MAG_W-1:0] r_den [QW+1];
    logic             r_neg [QW+1];
    logic             r_ovf [QW+1];

    logic [EXT_W-1:0] n_ext;
    logic [MAG_W-1:0] n_rem0;
    logic signed [QW-1:0] n_quot;
    logic signed [QW-1:0] r_quot;

    // numerator scaled by the weight fraction, split at the quotient width;
    // the upper part not below the divisor means the quotient overflows
    assign n_ext  = EXT_W'(i_num_mag) << FRAC_BITS;
    assign n_rem0 = n_ext[EXT_W-1:QW];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= n_rem0;
        r_low[0] <= n_ext[QW-1:0];
        r_q[0]   <= '0;
        r_den[0] <= i_den_mag;
        r_neg[0] <= i_neg;
        r_ovf[0] <= (n_rem0 >= i_den_mag);
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [MAG_W:0] n_trial;
        logic [MAG_W:0] n_diff;
        logic           n_ge;

        assign n_trial = {r_rem[k], r_low[k][QW-1]};
        assign n_diff  = n_trial - {1'b0, r_den[k]};
        assign n_ge    = (n_trial >= {1'b0, r_den[k]});

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= n_ge ? n_diff[MAG_W-1:0] : n_trial[MAG_W-1:0];
            r_low[k+1] <= {r_low[k][QW-2:0], 1'b0};
            r_q[k+1]   <= {r_q[k][QW-2:0], n_ge};
            r_den[k+1] <= r_den[k];
            r_neg[k+1] <= r_neg[k];
            r_ovf[k+1] <= r_ovf[k];
        end
    end

    // sign and clamp to the 32-bit range
    always_comb begin
        if (r_neg[QW]) begin
            if (r_ovf[QW] || (r_q[QW][QW-1] && (|r_q[QW][QW-2:0]))) begin
                n_quot = {1'b1, {(QW-1){1'b0}}};
            end else begin
                n_quot = -$signed(r_q[QW]);
            end
        end else begin
            if (r_ovf[QW] || r_q[QW][QW-1]) begin
                n_quot = {1'b0, {(QW-1){1'b1}}};
            end else begin
                n_quot = $signed(r_q[QW]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
    end

    assign o_quot = r_quot;

endmodule

[sv/triangle_barycentric_weights.sv]
// top level of the barycentric weight unit: config registers, pipeline and output stage
//
// channel   direction  handshake                       payload
// -------   ---------  ------------------------------  ------------------------------------
// config    in         i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
// point     in         i_start while o_busy is low     i_point_x, i_point_y
// weights   out        o_valid, one-cycle strobe       o_weight_first/second/third, o_degenerate
//
// a point transaction is taken every cycle while o_busy is low; its weights pass through
// 5 front-end stages, 34 divider stages (set by the 32 quotient bits) and one output stage
// the three quotients run in three parallel divider lanes, so throughput is one point per clock
// while o_busy is low; the weight channel has no back-pressure, so nothing ever stalls inside
// o_busy is high only while reset is asserted; reset clears valid bits and vertex registers
// config writes are always ready; an index past the last vertex register is dropped
module triangle_barycentric_weights #(
    parameter int COORD_BITS       = tbw_pkg::COORD_BITS_DEF,
    parameter int WEIGHT_FRAC_BITS = tbw_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tbw_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [COORD_BITS-1:0]               i_cfg_data,
    // point input
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic signed [COORD_BITS-1:0]        i_point_x,
    input  logic signed [COORD_BITS-1:0]        i_point_y,
    // weight output
    output logic                                o_valid,
    output logic signed [tbw_pkg::QUOT_W-1:0]   o_weight_first,
    output logic signed [tbw_pkg::QUOT_W-1:0]   o_weight_second,
    output logic signed [tbw_pkg::QUOT_W-1:0]   o_weight_third,
    output logic                                o_degenerate
);

    localparam int QW    = tbw_pkg::QUOT_W;
    localparam int MAG_W = tbw_pkg::mag_width(COORD_BITS);

    // 1.0 and -1.0 in the weight format, and a wider copy of 1.0 for the first-weight subtract
    localparam logic signed [QW-1:0] W_ONE     = QW'(1) << WEIGHT_FRAC_BITS;
    localparam logic signed [QW-1:0] W_NEG_ONE = -W_ONE;
    localparam logic signed [QW:0]   ONE_EXT   = (QW+1)'(1) << WEIGHT_FRAC_BITS;

    // vertex registers
    logic signed [COORD_BITS-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;

    // front end to divider lanes
    logic                 term_valid;
    logic [MAG_W-1:0]     term_num_mag [3];
    logic [MAG_W-1:0]     term_den_mag;
    tbw_pkg::t_term_flags term_flags;

    // lane results: second weight, third weight, quotient of the summed terms
    logic signed [QW-1:0] lane_quot [3];

    // side band that rides along with the divider lanes
    logic [tbw_pkg::DIV_LAT-1:0] r_vld_dly;
    logic [tbw_pkg::DIV_LAT-1:0] r_deg_dly;

    // output stage
    logic signed [QW:0]   n_w0_wide;
    logic signed [QW-1:0] n_w0;
    logic                 r_out_valid;
    logic signed [QW-1:0] r_w0, r_w1, r_w2;
    logic                 r_deg;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = ~i_rst_n;

    // config write decode; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= '0;
            r_ay <= '0;
            r_bx <= '0;
            r_by <= '0;
            r_cx <= '0;
            r_cy <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tbw_pkg::REG_A_X: r_ax <= i_cfg_data;
                tbw_pkg::REG_A_Y: r_ay <= i_cfg_data;
                tbw_pkg::REG_B_X: r_bx <= i_cfg_data;
                tbw_pkg::REG_B_Y: r_by <= i_cfg_data;
                tbw_pkg::REG_C_X: r_cx <= i_cfg_data;
                tbw_pkg::REG_C_Y: r_cy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // edge vectors, cross terms and their magnitudes
    tbw_terms #(
        .COORD_BITS (COORD_BITS)
    ) u_terms (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_start & ~o_busy),
        .i_ax      (r_ax),
        .i_ay      (r_ay),
        .i_bx      (r_bx),
        .i_by      (r_by),
        .i_cx      (r_cx),
        .i_cy      (r_cy),
        .i_px      (i_point_x),
        .i_py      (i_point_y),
        .o_valid   (term_valid),
        .o_num_mag (term_num_mag),
        .o_den_mag (term_den_mag),
        .o_flags   (term_flags)
    );

    // three divider lanes share the doubled area as divisor
    for (genvar k = 0; k < 3; k++) begin : g_lane
        tbw_div #(
            .MAG_W     (MAG_W),
            .FRAC_BITS (WEIGHT_FRAC_BITS)
        ) u_div (
            .i_clk     (i_clk),
            .i_num_mag (term_num_mag[k]),
            .i_den_mag (term_den_mag),
            .i_neg     (term_flags.neg[k]),
            .o_quot    (lane_quot[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_dly <= '0;
        end else begin
            r_vld_dly <= {r_vld_dly[tbw_pkg::DIV_LAT-2:0], term_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_deg_dly <= {r_deg_dly[tbw_pkg::DIV_LAT-2:0], term_flags.deg};
    end

    // first weight is 1.0 minus the summed-term quotient, clamped again
    assign n_w0_wide = ONE_EXT - (QW+1)'(lane_quot[2]);

    always_comb begin
        if (n_w0_wide[QW] != n_w0_wide[QW-1]) begin
            n_w0 = n_w0_wide[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
        end else begin
            n_w0 = n_w0_wide[QW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_vld_dly[tbw_pkg::DIV_LAT-1];
        end
    end

    // zero area forces the fixed (-1, 1, 1) answer
    always_ff @(posedge i_clk) begin
        if (r_deg_dly[tbw_pkg::DIV_LAT-1]) begin
            r_w0 <= W_NEG_ONE;
            r_w1 <= W_ONE;
            r_w2 <= W_ONE;
        end else begin
            r_w0 <= n_w0;
            r_w1 <= lane_quot[0];
            r_w2 <= lane_quot[1];
        end
        r_deg <= r_deg_dly[tbw_pkg::DIV_LAT-1];
    end

    assign o_valid         = r_out_valid;
    assign o_weight_first  = r_w0;
    assign o_weight_second = r_w1;
    assign o_weight_third  = r_w2;
    assign o_degenerate    = r_deg;

endmodule

[sv/tbw_checker.sv]
// port-level checks for the barycentric weight unit, bound to the top level
module tbw_checker #(
    parameter int WEIGHT_FRAC_BITS = tbw_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_start,
    input logic                              o_busy,
    input logic                              o_valid,
    input logic signed [tbw_pkg::QUOT_W-1:0] o_weight_first,
    input logic signed [tbw_pkg::QUOT_W-1:0] o_weight_second,
    input logic signed [tbw_pkg::QUOT_W-1:0] o_weight_third,
    input logic                              o_degenerate
);

    localparam int QW = tbw_pkg::QUOT_W;
    localparam logic signed [QW-1:0] W_ONE = QW'(1) << WEIGHT_FRAC_BITS;

    // every accepted point produces a result strobe
    a_fwd_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##(tbw_pkg::PIPE_LAT) o_valid)
        else $error("accepted point produced no result");

    // no strobe without a matching accepted point
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, tbw_pkg::PIPE_LAT))
        else $error("result strobe without an accepted point");

    // zero-area results carry the fixed weights
    a_degenerate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |->
            (o_weight_first == -W_ONE && o_weight_second == W_ONE
             && o_weight_third == W_ONE))
        else $error("degenerate result with wrong weights");

    // reset flushes the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

endmodule

bind triangle_barycentric_weights tbw_checker #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
) u_tbw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (i_start),
    .o_busy          (o_busy),
    .o_valid         (o_valid),
    .o_weight_first  (o_weight_first),
    .o_weight_second (o_weight_second),
    .o_weight_third  (o_weight_third),
    .o_degenerate    (o_degenerate)
);
